>>> hw/rtl/sgdmf_pkg.sv
// ============================================================================
// sgdmf_pkg
// Shared types, constants and fixed-point helpers for the SGD factor update unit.
// ============================================================================
package sgdmf_pkg;

    localparam int USER_ROWS       = 1024;   // power of two
    localparam int ITEM_ROWS       = 1024;   // power of two
    localparam int MAX_RANK        = 64;     // power of two
    localparam int LATENT_BASE     = 3;
    localparam int USER_BIAS_SLOT  = 1;
    localparam int ITEM_BIAS_SLOT  = 2;

    localparam int RANK_W     = $clog2(MAX_RANK);
    localparam int RANK_CNT_W = $clog2(MAX_RANK + 1);
    localparam int UROW_W     = $clog2(USER_ROWS);
    localparam int IROW_W     = $clog2(ITEM_ROWS);
    localparam int UADDR_W    = UROW_W + RANK_W;
    localparam int IADDR_W    = IROW_W + RANK_W;
    localparam int USER_DEPTH = USER_ROWS * MAX_RANK;
    localparam int ITEM_DEPTH = ITEM_ROWS * MAX_RANK;
    // rounded products are below 2^39 in magnitude, MAX_RANK of them summed
    localparam int ACC_W      = 41 + RANK_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic signed [63:0] HALF_LSB = 64'sd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_RANK     = 3'd0,
        CFG_LEARNING_RATE   = 3'd1,
        CFG_REG_STRENGTH    = 3'd2,
        CFG_BIAS_RATE_RATIO = 3'd3,
        CFG_BIAS_REG_RATIO  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_TRAIN     = 2'd0,
        KIND_PREDICT   = 2'd1,
        KIND_LOAD_USER = 2'd2,
        KIND_LOAD_ITEM = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         user_index;
        logic [9:0]         item_index;
        logic [5:0]         slot_index;
        logic signed [31:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic signed [31:0] error_value;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] value;
    } sat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DOT_RD,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_DOT_END,
        ST_ERR,
        ST_F_RD,
        ST_F_CAP,
        ST_F_LAT,
        ST_F_T1,
        ST_F_D,
        ST_F_RATE,
        ST_F_WR,
        ST_B_PR,
        ST_B_PL,
        ST_B_RD,
        ST_B_CAP,
        ST_B_M1,
        ST_B_D,
        ST_B_R,
        ST_B_WR,
        ST_FIN
    } state_t;

    // clamp to signed 32 bits, flag when clipped
    function automatic sat_t sat32(input logic signed [63:0] x);
        sat_t r;
        if (x > 64'sd2147483647) begin
            r.hit   = 1'b1;
            r.value = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r.hit   = 1'b1;
            r.value = 32'sh8000_0000;
        end else begin
            r.hit   = 1'b0;
            r.value = x[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/sgdmf_ram.sv
// ============================================================================
// sgdmf_ram
// Generic single-port synchronous RAM, read-first, with registered read data.
// ============================================================================
module sgdmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/sgd_matrix_factor_update_unit.sv
// ============================================================================
// sgd_matrix_factor_update_unit
// Biased SGD matrix factorization engine over two factor-table RAMs, Q8.24.
// ============================================================================
// Usage:
//   s_* channel (valid/ready) carries one item: train, predict, or an element
//   load into the user or item table. m_* channel (valid/ready) returns one
//   result per item: prediction, error_value and a saturation flag.
//   cfg_we/cfg_addr/cfg_wdata write the five control registers; write only
//   while the unit is idle.
// Sequencing (n = active rank, capped at MAX_RANK):
//   load    : written on transfer, then through the final step to the result register.
//   predict : the dot product over n elements takes one RAM read, one
//             multiply and one accumulate per element on a single multiplier.
//   train   : the dot product, then each latent pair needs six
//             multiplies serialized on the shared multiplier plus a read.
//   One item is in work at a time; s_ready is high only while idle.
// Reset: control registers return to their defaults and the sequencer to
//   idle. Table RAMs are not cleared; every element must be loaded before use.
// Stall: a finished result sits in the output register; the next item is
//   taken meanwhile and holds in its final step until that result transfers.
// ============================================================================
module sgd_matrix_factor_update_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sgdmf_pkg::in_item_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sgdmf_pkg::out_item_t            m_data,
    input  logic                            cfg_we,
    input  logic [sgdmf_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sgdmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [6:0]  active_rank_reg;
    logic [30:0] learning_rate_reg;
    logic [30:0] reg_strength_reg;
    logic [30:0] bias_rate_ratio_reg;
    logic [30:0] bias_reg_ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rank_reg     <= 7'd64;
            learning_rate_reg   <= 31'd167772;
            reg_strength_reg    <= 31'd17;
            bias_rate_ratio_reg <= 31'd8388608;
            bias_reg_ratio_reg  <= 31'd1677722;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                sgdmf_pkg::CFG_ACTIVE_RANK:     active_rank_reg     <= cfg_wdata[6:0];
                sgdmf_pkg::CFG_LEARNING_RATE:   learning_rate_reg   <= cfg_wdata;
                sgdmf_pkg::CFG_REG_STRENGTH:    reg_strength_reg    <= cfg_wdata;
                sgdmf_pkg::CFG_BIAS_RATE_RATIO: bias_rate_ratio_reg <= cfg_wdata;
                sgdmf_pkg::CFG_BIAS_REG_RATIO:  bias_reg_ratio_reg  <= cfg_wdata;
                default: ;  // unknown register: ignored
            endcase
        end
    end

    // rank in use, capped at the table row length
    logic [sgdmf_pkg::RANK_CNT_W-1:0] rank_n;
    always_comb begin
        if (32'(active_rank_reg) > sgdmf_pkg::MAX_RANK) begin
            rank_n = sgdmf_pkg::RANK_CNT_W'(sgdmf_pkg::MAX_RANK);
        end else begin
            rank_n = sgdmf_pkg::RANK_CNT_W'(active_rank_reg);
        end
    end

    // ---------------- sequencer and datapath registers ----------------
    sgdmf_pkg::state_t state_reg, state_next;
    sgdmf_pkg::in_item_t item_reg;
    logic [sgdmf_pkg::RANK_CNT_W-1:0] cnt_reg;
    logic                             side_reg;   // 0: user element, 1: item element
    logic signed [sgdmf_pkg::ACC_W-1:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] pred_reg, err_reg, uk_reg, vk_reg, t1_reg, d_reg;
    logic signed [31:0] brate_reg, blam_reg;
    logic               sat_reg;
    logic               m_valid_reg;
    sgdmf_pkg::out_item_t m_data_reg;

    logic s_fire;
    assign s_ready = (state_reg == sgdmf_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    logic is_load;
    assign is_load = (s_data.kind == sgdmf_pkg::KIND_LOAD_USER) ||
                     (s_data.kind == sgdmf_pkg::KIND_LOAD_ITEM);

    logic cnt_last;   // current element is the final one in use
    assign cnt_last = (cnt_reg + 1'b1) >= rank_n;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sgdmf_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (is_load) begin
                        state_next = sgdmf_pkg::ST_FIN;
                    end else if (rank_n == '0) begin
                        state_next = sgdmf_pkg::ST_DOT_END;
                    end else begin
                        state_next = sgdmf_pkg::ST_DOT_RD;
                    end
                end
            end
            sgdmf_pkg::ST_DOT_RD:  state_next = sgdmf_pkg::ST_DOT_MUL;
            sgdmf_pkg::ST_DOT_MUL: state_next = sgdmf_pkg::ST_DOT_ACC;
            sgdmf_pkg::ST_DOT_ACC: begin
                state_next = cnt_last ? sgdmf_pkg::ST_DOT_END : sgdmf_pkg::ST_DOT_RD;
            end
            sgdmf_pkg::ST_DOT_END: begin
                state_next = (item_reg.kind == sgdmf_pkg::KIND_TRAIN) ?
                             sgdmf_pkg::ST_ERR : sgdmf_pkg::ST_FIN;
            end
            sgdmf_pkg::ST_ERR: begin
                state_next = (32'(rank_n) > sgdmf_pkg::LATENT_BASE) ?
                             sgdmf_pkg::ST_F_RD : sgdmf_pkg::ST_B_PR;
            end
            sgdmf_pkg::ST_F_RD:   state_next = sgdmf_pkg::ST_F_CAP;
            sgdmf_pkg::ST_F_CAP:  state_next = sgdmf_pkg::ST_F_LAT;
            sgdmf_pkg::ST_F_LAT:  state_next = sgdmf_pkg::ST_F_T1;
            sgdmf_pkg::ST_F_T1:   state_next = sgdmf_pkg::ST_F_D;
            sgdmf_pkg::ST_F_D:    state_next = sgdmf_pkg::ST_F_RATE;
            sgdmf_pkg::ST_F_RATE: state_next = sgdmf_pkg::ST_F_WR;
            sgdmf_pkg::ST_F_WR: begin
                if (!side_reg) begin
                    state_next = sgdmf_pkg::ST_F_LAT;
                end else begin
                    state_next = cnt_last ? sgdmf_pkg::ST_B_PR : sgdmf_pkg::ST_F_RD;
                end
            end
            sgdmf_pkg::ST_B_PR:  state_next = sgdmf_pkg::ST_B_PL;
            sgdmf_pkg::ST_B_PL:  state_next = sgdmf_pkg::ST_B_RD;
            sgdmf_pkg::ST_B_RD:  state_next = sgdmf_pkg::ST_B_CAP;
            sgdmf_pkg::ST_B_CAP: state_next = sgdmf_pkg::ST_B_M1;
            sgdmf_pkg::ST_B_M1:  state_next = sgdmf_pkg::ST_B_D;
            sgdmf_pkg::ST_B_D:   state_next = sgdmf_pkg::ST_B_R;
            sgdmf_pkg::ST_B_R:   state_next = sgdmf_pkg::ST_B_WR;
            sgdmf_pkg::ST_B_WR: begin
                state_next = side_reg ? sgdmf_pkg::ST_FIN : sgdmf_pkg::ST_B_M1;
            end
            sgdmf_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = sgdmf_pkg::ST_IDLE;
                end
            end
            default: state_next = sgdmf_pkg::ST_IDLE;
        endcase
    end

    // ---------------- shared multiplier and rounding ----------------
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] rate_s, lam_s, brr_s, bgr_s;
    logic signed [31:0] self_v, other_v;
    logic signed [63:0] rnd;
    sgdmf_pkg::sat_t    qm;

    assign rate_s  = $signed({1'b0, learning_rate_reg});
    assign lam_s   = $signed({1'b0, reg_strength_reg});
    assign brr_s   = $signed({1'b0, bias_rate_ratio_reg});
    assign bgr_s   = $signed({1'b0, bias_reg_ratio_reg});
    assign self_v  = side_reg ? vk_reg : uk_reg;
    assign other_v = side_reg ? uk_reg : vk_reg;

    // round to nearest, ties up: floor((p + 2^23) / 2^24)
    assign rnd = (prod_reg + sgdmf_pkg::HALF_LSB) >>> 24;
    assign qm  = sgdmf_pkg::sat32(rnd);

    // ---------------- table RAMs ----------------
    logic                              u_we, v_we;
    logic [sgdmf_pkg::UADDR_W-1:0]     u_addr;
    logic [sgdmf_pkg::IADDR_W-1:0]     v_addr;
    logic [31:0]                       u_wdata, v_wdata, u_rdata, v_rdata;
    logic [sgdmf_pkg::RANK_W-1:0]      elem_slot, u_slot, v_slot;
    sgdmf_pkg::sat_t                   upd;   // self + rate-scaled step

    assign upd = sgdmf_pkg::sat32(64'(self_v) + 64'(qm.value));

    // ---------------- control outputs ----------------
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        u_we      = 1'b0;
        v_we      = 1'b0;
        u_wdata   = upd.value;
        v_wdata   = upd.value;
        elem_slot = cnt_reg[sgdmf_pkg::RANK_W-1:0];
        u_slot    = elem_slot;
        v_slot    = elem_slot;
        u_addr    = {item_reg.user_index[sgdmf_pkg::UROW_W-1:0], u_slot};
        v_addr    = {item_reg.item_index[sgdmf_pkg::IROW_W-1:0], v_slot};
        unique case (state_reg)
            sgdmf_pkg::ST_IDLE: begin
                u_addr  = {s_data.user_index[sgdmf_pkg::UROW_W-1:0],
                           s_data.slot_index[sgdmf_pkg::RANK_W-1:0]};
                v_addr  = {s_data.item_index[sgdmf_pkg::IROW_W-1:0],
                           s_data.slot_index[sgdmf_pkg::RANK_W-1:0]};
                u_wdata = s_data.data_value;
                v_wdata = s_data.data_value;
                u_we    = s_fire && (s_data.kind == sgdmf_pkg::KIND_LOAD_USER) &&
                          (32'(s_data.slot_index) < sgdmf_pkg::MAX_RANK);
                v_we    = s_fire && (s_data.kind == sgdmf_pkg::KIND_LOAD_ITEM) &&
                          (32'(s_data.slot_index) < sgdmf_pkg::MAX_RANK);
            end
            sgdmf_pkg::ST_DOT_MUL: begin
                mul_a = $signed(u_rdata);
                mul_b = $signed(v_rdata);
            end
            sgdmf_pkg::ST_F_LAT: begin
                mul_a = err_reg;
                mul_b = other_v;
            end
            sgdmf_pkg::ST_F_T1: begin
                mul_a = lam_s;
                mul_b = self_v;
            end
            sgdmf_pkg::ST_F_RATE: begin
                mul_a = rate_s;
                mul_b = d_reg;
            end
            sgdmf_pkg::ST_F_WR: begin
                u_we = !side_reg;
                v_we = side_reg;
            end
            sgdmf_pkg::ST_B_PR: begin
                mul_a = brr_s;
                mul_b = rate_s;
            end
            sgdmf_pkg::ST_B_PL: begin
                mul_a = bgr_s;
                mul_b = lam_s;
            end
            sgdmf_pkg::ST_B_RD, sgdmf_pkg::ST_B_WR: begin
                u_slot = sgdmf_pkg::RANK_W'(sgdmf_pkg::USER_BIAS_SLOT);
                v_slot = sgdmf_pkg::RANK_W'(sgdmf_pkg::ITEM_BIAS_SLOT);
                u_addr = {item_reg.user_index[sgdmf_pkg::UROW_W-1:0], u_slot};
                v_addr = {item_reg.item_index[sgdmf_pkg::IROW_W-1:0], v_slot};
                u_we   = (state_reg == sgdmf_pkg::ST_B_WR) && !side_reg;
                v_we   = (state_reg == sgdmf_pkg::ST_B_WR) && side_reg;
            end
            sgdmf_pkg::ST_B_M1: begin
                mul_a = blam_reg;
                mul_b = self_v;
            end
            sgdmf_pkg::ST_B_R: begin
                mul_a = brate_reg;
                mul_b = d_reg;
            end
            default: ;
        endcase
    end

    sgdmf_ram #(.WIDTH(32), .DEPTH(sgdmf_pkg::USER_DEPTH)) u_user_ram (
        .aclk  (aclk),
        .we    (u_we),
        .addr  (u_addr),
        .wdata (u_wdata),
        .rdata (u_rdata)
    );

    sgdmf_ram #(.WIDTH(32), .DEPTH(sgdmf_pkg::ITEM_DEPTH)) u_item_ram (
        .aclk  (aclk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (v_wdata),
        .rdata (v_rdata)
    );

    // ---------------- datapath ----------------
    sgdmf_pkg::sat_t acc_sat, err_sat, diff_f, diff_b;
    assign acc_sat = sgdmf_pkg::sat32(64'(acc_reg));
    assign err_sat = sgdmf_pkg::sat32(64'(item_reg.data_value) - 64'(pred_reg));
    assign diff_f  = sgdmf_pkg::sat32(64'(t1_reg) - 64'(qm.value));
    assign diff_b  = sgdmf_pkg::sat32(64'(err_reg) - 64'(qm.value));

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            sgdmf_pkg::ST_IDLE: begin
                if (s_fire) begin
                    item_reg <= s_data;
                    acc_reg  <= '0;
                    cnt_reg  <= '0;
                    pred_reg <= '0;
                    err_reg  <= '0;
                    sat_reg  <= 1'b0;
                end
            end
            sgdmf_pkg::ST_DOT_ACC: begin
                acc_reg <= acc_reg + rnd[sgdmf_pkg::ACC_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            sgdmf_pkg::ST_DOT_END: begin
                pred_reg <= acc_sat.value;
                sat_reg  <= sat_reg | acc_sat.hit;
            end
            sgdmf_pkg::ST_ERR: begin
                err_reg <= err_sat.value;
                sat_reg <= sat_reg | err_sat.hit;
                cnt_reg <= sgdmf_pkg::RANK_CNT_W'(sgdmf_pkg::LATENT_BASE);
            end
            sgdmf_pkg::ST_F_CAP, sgdmf_pkg::ST_B_CAP: begin
                uk_reg   <= $signed(u_rdata);
                vk_reg   <= $signed(v_rdata);
                side_reg <= 1'b0;
            end
            sgdmf_pkg::ST_F_T1: begin
                t1_reg  <= qm.value;
                sat_reg <= sat_reg | qm.hit;
            end
            sgdmf_pkg::ST_F_D: begin
                d_reg   <= diff_f.value;
                sat_reg <= sat_reg | qm.hit | diff_f.hit;
            end
            sgdmf_pkg::ST_F_WR: begin
                sat_reg <= sat_reg | qm.hit | upd.hit;
                if (!side_reg) begin
                    uk_reg   <= upd.value;   // item update uses the new user value
                    side_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            sgdmf_pkg::ST_B_PL: begin
                brate_reg <= qm.value;
                sat_reg   <= sat_reg | qm.hit;
            end
            sgdmf_pkg::ST_B_RD: begin
                blam_reg <= qm.value;
                sat_reg  <= sat_reg | qm.hit;
            end
            sgdmf_pkg::ST_B_D: begin
                d_reg   <= diff_b.value;
                sat_reg <= sat_reg | qm.hit | diff_b.hit;
            end
            sgdmf_pkg::ST_B_WR: begin
                sat_reg  <= sat_reg | qm.hit | upd.hit;
                side_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- state and output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sgdmf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == sgdmf_pkg::ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == sgdmf_pkg::ST_FIN) && out_free) begin
            m_data_reg.prediction  <= pred_reg;
            m_data_reg.error_value <= err_reg;
            m_data_reg.saturated   <= sat_reg;
        end
    end

`ifndef SYNTH
    // a new result appears only out of the final step
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == sgdmf_pkg::ST_FIN))
        else $error("result raised outside final step");

    // tables are written only on a load transfer or in the write-back steps
    a_write_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (u_we || v_we) |-> (state_reg == sgdmf_pkg::ST_IDLE ||
                            state_reg == sgdmf_pkg::ST_F_WR ||
                            state_reg == sgdmf_pkg::ST_B_WR))
        else $error("table write outside write-back");

    // latent loop stays within the features in use
    a_feature_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sgdmf_pkg::ST_F_RD) |->
            (32'(cnt_reg) >= sgdmf_pkg::LATENT_BASE && cnt_reg < rank_n))
        else $error("feature index out of range");

    // loads report a zero result with no saturation
    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sgdmf_pkg::ST_FIN &&
         (item_reg.kind == sgdmf_pkg::KIND_LOAD_USER ||
          item_reg.kind == sgdmf_pkg::KIND_LOAD_ITEM))
        |-> (pred_reg == '0 && err_reg == '0 && !sat_reg))
        else $error("load produced nonzero result");
`endif

endmodule

>>> bench/tb_sgd_matrix_factor_update_unit.sv
// ============================================================================
// tb_sgd_matrix_factor_update_unit
// Self-checking bench for the SGD factor update unit: directed corner items,
// register sweeps and random train/predict/load traffic under random idling,
// checked against an in-bench fixed-point predictor of both factor tables.
// ============================================================================
module tb_sgd_matrix_factor_update_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes with no register behind them
    localparam logic [sgdmf_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX  = 3'd7;
    localparam logic [sgdmf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;
    localparam int POOL = 6;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    sgdmf_pkg::in_item_t              s_data = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    sgdmf_pkg::out_item_t             m_data;
    logic                             cfg_we = 1'b0;
    logic [sgdmf_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [sgdmf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    sgd_matrix_factor_update_unit dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_we, .cfg_addr, .cfg_wdata
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: shadow tables, written-element marks, registers
    // ------------------------------------------------------------------
    int        user_tab [sgdmf_pkg::USER_DEPTH];
    int        item_tab [sgdmf_pkg::ITEM_DEPTH];
    bit        user_set [sgdmf_pkg::USER_DEPTH];
    bit        item_set [sgdmf_pkg::ITEM_DEPTH];
    bit [6:0]  rank_reg = 7'd64;
    int        mu_reg = 167772;
    int        lambda_reg = 17;
    int        brate_reg = 8388608;
    int        breg_reg = 1677722;
    bit        clip_seen;

    sgdmf_pkg::out_item_t expected_q[$];
    int        fail_count = 0;
    int        src_idle = 0;     // percent of sends preceded by a gap
    int        snk_stall = 0;    // percent of cycles with m_ready low
    int        hold_left = 0;    // long receiver hold-off, in cycles
    int        user_pool[POOL];
    int        item_pool[POOL];

    // clamp to Q8.24 range, note any clipping
    function automatic int clip32(longint x);
        if (x > 64'sd2147483647) begin
            clip_seen = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            clip_seen = 1'b1;
            return 32'h8000_0000;
        end
        return int'(x);
    endfunction

    // exact product scaled by 2^-24, nearest with ties upward
    function automatic longint qprod(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd8388608;
        return p >>> 24;
    endfunction

    function automatic int qm(int a, int b);
        return clip32(qprod(a, b));
    endfunction

    function automatic int qa(int a, int b);
        return clip32(longint'(a) + longint'(b));
    endfunction

    function automatic int qs(int a, int b);
        return clip32(longint'(a) - longint'(b));
    endfunction

    function automatic int ranks_used();
        return (rank_reg > sgdmf_pkg::MAX_RANK) ? sgdmf_pkg::MAX_RANK : int'(rank_reg);
    endfunction

    // advance the shadow tables by one item and return its result
    function automatic sgdmf_pkg::out_item_t factor_step(sgdmf_pkg::in_item_t it);
        sgdmf_pkg::out_item_t r;
        int ub, ib, n, pred, err, brate, blam, ubs, ibs;
        longint acc;
        ub = int'(it.user_index) * sgdmf_pkg::MAX_RANK;
        ib = int'(it.item_index) * sgdmf_pkg::MAX_RANK;
        ubs = ub + sgdmf_pkg::USER_BIAS_SLOT;
        ibs = ib + sgdmf_pkg::ITEM_BIAS_SLOT;
        n = ranks_used();
        pred = 0;
        err = 0;
        acc = 0;
        clip_seen = 1'b0;
        case (sgdmf_pkg::kind_t'(it.kind))
            sgdmf_pkg::KIND_LOAD_USER: begin
                user_tab[ub + it.slot_index] = it.data_value;
            end
            sgdmf_pkg::KIND_LOAD_ITEM: begin
                item_tab[ib + it.slot_index] = it.data_value;
            end
            default: begin
                for (int k = 0; k < n; k++) acc += qprod(user_tab[ub + k], item_tab[ib + k]);
                pred = clip32(acc);
                if (sgdmf_pkg::kind_t'(it.kind) == sgdmf_pkg::KIND_TRAIN) begin
                    err = qs(it.data_value, pred);
                    for (int k = sgdmf_pkg::LATENT_BASE; k < n; k++) begin
                        user_tab[ub + k] = qa(user_tab[ub + k], qm(mu_reg,
                            qs(qm(err, item_tab[ib + k]), qm(lambda_reg, user_tab[ub + k]))));
                        item_tab[ib + k] = qa(item_tab[ib + k], qm(mu_reg,
                            qs(qm(err, user_tab[ub + k]), qm(lambda_reg, item_tab[ib + k]))));
                    end
                    brate = qm(brate_reg, mu_reg);
                    blam = qm(breg_reg, lambda_reg);
                    user_tab[ubs] = qa(user_tab[ubs],
                        qm(brate, qs(err, qm(blam, user_tab[ubs]))));
                    item_tab[ibs] = qa(item_tab[ibs],
                        qm(brate, qs(err, qm(blam, item_tab[ibs]))));
                end
            end
        endcase
        r.prediction = pred;
        r.error_value = err;
        r.saturated = clip_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Q8.24 value: mostly near +-1.0, sometimes wide, sometimes the rails
    function automatic int pick_q();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 10) return int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        if (sel < 13) return int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
        if (sel == 13) return 32'h7FFF_FFFF;
        if (sel == 14) return 32'h8000_0000;
        return int'($urandom);
    endfunction

    // one transfer on the input channel; the item is predicted when accepted
    task automatic send_item(sgdmf_pkg::in_item_t it);
        if ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.kind == sgdmf_pkg::KIND_LOAD_USER)
            user_set[int'(it.user_index) * sgdmf_pkg::MAX_RANK + it.slot_index] = 1'b1;
        if (it.kind == sgdmf_pkg::KIND_LOAD_ITEM)
            item_set[int'(it.item_index) * sgdmf_pkg::MAX_RANK + it.slot_index] = 1'b1;
        expected_q.push_back(factor_step(it));
    endtask

    task automatic send_fields(sgdmf_pkg::kind_t k, int u, int i, int slot, int val);
        sgdmf_pkg::in_item_t it;
        it.kind = k;
        it.user_index = u[9:0];
        it.item_index = i[9:0];
        it.slot_index = slot[5:0];
        it.data_value = val;
        send_item(it);
    endtask

    // load every element a train or predict on (u, i) will read
    task automatic fill_rows(int u, int i);
        int n;
        n = (ranks_used() < sgdmf_pkg::LATENT_BASE) ? sgdmf_pkg::LATENT_BASE : ranks_used();
        for (int k = 0; k < n; k++) begin
            if (!user_set[u * sgdmf_pkg::MAX_RANK + k])
                send_fields(sgdmf_pkg::KIND_LOAD_USER, u, $urandom_range(0, 1023), k,
                            pick_q());
            if (!item_set[i * sgdmf_pkg::MAX_RANK + k])
                send_fields(sgdmf_pkg::KIND_LOAD_ITEM, $urandom_range(0, 1023), i, k,
                            pick_q());
        end
    endtask

    task automatic use_rows(sgdmf_pkg::kind_t k, int u, int i, int val);
        fill_rows(u, i);
        send_fields(k, u, i, $urandom_range(0, 63), val);
    endtask

    // register write, only once the unit has drained
    task automatic write_reg(logic [sgdmf_pkg::CFG_IDX_W-1:0] idx,
                             logic [sgdmf_pkg::CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sgdmf_pkg::CFG_ACTIVE_RANK:     rank_reg = val[6:0];
            sgdmf_pkg::CFG_LEARNING_RATE:   mu_reg = int'({1'b0, val});
            sgdmf_pkg::CFG_REG_STRENGTH:    lambda_reg = int'({1'b0, val});
            sgdmf_pkg::CFG_BIAS_RATE_RATIO: brate_reg = int'({1'b0, val});
            sgdmf_pkg::CFG_BIAS_REG_RATIO:  breg_reg = int'({1'b0, val});
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        fail_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off, per-field compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        sgdmf_pkg::out_item_t want;
        if (m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_data.prediction !== want.prediction)
                    report_mismatch("prediction", m_data.prediction, want.prediction);
                if (m_data.error_value !== want.error_value)
                    report_mismatch("error_value", m_data.error_value, want.error_value);
                if (m_data.saturated !== want.saturated)
                    report_mismatch("saturated", m_data.saturated, want.saturated);
            end
        end
        m_ready <= aresetn && hold_left == 0 && $urandom_range(0, 99) >= snk_stall;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // every kind, rails of every field, rank below four, above the table width,
    // and writes to an index with no register
    task automatic test_directed();
        write_reg(sgdmf_pkg::CFG_ACTIVE_RANK, 31'd4);
        use_rows(sgdmf_pkg::KIND_PREDICT, user_pool[0], item_pool[0], 0);
        use_rows(sgdmf_pkg::KIND_TRAIN, user_pool[0], item_pool[0], 32'h7FFF_FFFF);
        use_rows(sgdmf_pkg::KIND_TRAIN, user_pool[1], item_pool[1], 32'h8000_0000);
        send_fields(sgdmf_pkg::KIND_LOAD_USER, 1023, 1023, 63, 32'h7FFF_FFFF);
        send_fields(sgdmf_pkg::KIND_LOAD_ITEM, 0, 0, 63, 32'h8000_0000);
        send_fields(sgdmf_pkg::KIND_LOAD_USER, user_pool[2], 0, 3, 32'h7FFF_FFFF);
        send_fields(sgdmf_pkg::KIND_LOAD_ITEM, 0, item_pool[2], 3, 32'h7FFF_FFFF);
        use_rows(sgdmf_pkg::KIND_PREDICT, user_pool[2], item_pool[2], 0);
        use_rows(sgdmf_pkg::KIND_TRAIN, user_pool[2], item_pool[2], 0);
        write_reg(CFG_SPARE_IDX, 31'h7FFF_FFFF);
        write_reg(CFG_UNUSED_IDX, 31'd0);
        for (int r = 0; r < 4; r++) begin
            write_reg(sgdmf_pkg::CFG_ACTIVE_RANK, r[sgdmf_pkg::CFG_DATA_W-1:0]);
            use_rows(sgdmf_pkg::KIND_TRAIN, user_pool[3], item_pool[3], pick_q());
            use_rows(sgdmf_pkg::KIND_PREDICT, user_pool[3], item_pool[3], 0);
        end
        write_reg(sgdmf_pkg::CFG_ACTIVE_RANK, 31'd127);
        use_rows(sgdmf_pkg::KIND_TRAIN, user_pool[4], item_pool[4], pick_q());
        write_reg(sgdmf_pkg::CFG_ACTIVE_RANK, 31'd64);
        use_rows(sgdmf_pkg::KIND_PREDICT, user_pool[4], item_pool[4], 0);
        use_rows(sgdmf_pkg::KIND_TRAIN, user_pool[4], item_pool[4], 32'h0100_0000);
    endtask

    // learning and regularization registers at their rails and in between
    task automatic test_register_sweep();
        logic [sgdmf_pkg::CFG_DATA_W-1:0] vals[4];
        vals = '{31'd0, 31'h7FFF_FFFF, 31'd167772, 31'h0100_0000};
        write_reg(sgdmf_pkg::CFG_ACTIVE_RANK, 31'd6);
        for (int v = 0; v < 4; v++) begin
            write_reg(sgdmf_pkg::CFG_LEARNING_RATE, vals[v]);
            write_reg(sgdmf_pkg::CFG_REG_STRENGTH, vals[(v + 1) % 4]);
            write_reg(sgdmf_pkg::CFG_BIAS_RATE_RATIO, vals[(v + 2) % 4]);
            write_reg(sgdmf_pkg::CFG_BIAS_REG_RATIO, vals[(v + 3) % 4]);
            repeat (3) use_rows(sgdmf_pkg::KIND_TRAIN, user_pool[v], item_pool[v], pick_q());
        end
        write_reg(sgdmf_pkg::CFG_LEARNING_RATE, 31'd167772);
        write_reg(sgdmf_pkg::CFG_REG_STRENGTH, 31'd17);
        write_reg(sgdmf_pkg::CFG_BIAS_RATE_RATIO, 31'd8388608);
        write_reg(sgdmf_pkg::CFG_BIAS_REG_RATIO, 31'd1677722);
    endtask

    // mostly train/predict on loaded rows, some reloads, some stray loads
    task automatic test_random(int count, int rank, int src, int snk);
        int sel, u, i;
        write_reg(sgdmf_pkg::CFG_ACTIVE_RANK, rank[sgdmf_pkg::CFG_DATA_W-1:0]);
        write_reg(sgdmf_pkg::CFG_LEARNING_RATE,
                  sgdmf_pkg::CFG_DATA_W'($urandom_range(0, 32'h0080_0000)));
        src_idle = src;
        snk_stall = snk;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            u = user_pool[$urandom_range(0, POOL - 1)];
            i = item_pool[$urandom_range(0, POOL - 1)];
            if (sel < 55)
                use_rows(sgdmf_pkg::KIND_TRAIN, u, i, pick_q());
            else if (sel < 75)
                use_rows(sgdmf_pkg::KIND_PREDICT, u, i, int'($urandom));
            else if (sel < 83)
                send_fields(sgdmf_pkg::KIND_LOAD_USER, u, $urandom_range(0, 1023),
                            $urandom_range(0, 63), pick_q());
            else if (sel < 91)
                send_fields(sgdmf_pkg::KIND_LOAD_ITEM, $urandom_range(0, 1023), i,
                            $urandom_range(0, 63), pick_q());
            else
                send_fields(sgdmf_pkg::kind_t'($urandom_range(2, 3)),
                            $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 63), int'($urandom));
        end
    endtask

    // receiver holds off long while loads keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(sgdmf_pkg::CFG_ACTIVE_RANK, 31'd4);
        src_idle = 0;
        snk_stall = 0;
        hold_left = 400;
        repeat (12) send_fields(sgdmf_pkg::kind_t'($urandom_range(2, 3)),
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 63), pick_q());
        repeat (4) use_rows(sgdmf_pkg::KIND_PREDICT, user_pool[0], item_pool[0], 0);
    endtask

    initial begin
        user_pool = '{0, 1023, 341, 682, 0, 0};
        item_pool = '{1023, 0, 682, 341, 0, 0};
        for (int p = 4; p < POOL; p++) begin
            user_pool[p] = $urandom_range(0, 1023);
            item_pool[p] = $urandom_range(0, 1023);
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_sweep();
        test_random(200, 4, 0, 0);
        test_random(200, 7, 60, 0);
        test_random(200, 5, 0, 60);
        test_random(200, 12, 27, 27);
        test_backpressure();
        test_random(60, 9, 0, 0);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #(8 * 3_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
